/* src/demg_pkg.sv */
// ----------------------------------------------------------------------------
// demg_pkg
// Shared types, kernel weights and divisor codes for the diagonal edge block.
// ----------------------------------------------------------------------------
package demg_pkg;

	typedef logic [7:0]        pix_t;
	typedef logic [9:0]        mag_t;
	typedef logic signed [11:0] sum_t;
	typedef logic signed [3:0] wsum_t;
	typedef logic [1:0]        div_t;

	localparam div_t DIV_ONE   = 2'd0;
	localparam div_t DIV_THREE = 2'd1;
	localparam div_t DIV_FOUR  = 2'd2;

	// Weights indexed [row][column], row 0 above, column 0 left.
	localparam logic signed [2:0] W45 [3][3] = '{
		'{-3'sd2, -3'sd1,  3'sd0},
		'{-3'sd1,  3'sd0,  3'sd1},
		'{ 3'sd0,  3'sd1,  3'sd2}
	};
	localparam logic signed [2:0] W135 [3][3] = '{
		'{ 3'sd0,  3'sd1,  3'sd2},
		'{-3'sd1,  3'sd0,  3'sd1},
		'{-3'sd2, -3'sd1,  3'sd0}
	};

	// One neighbourhood: px[column][row], with column and row presence masks.
	typedef struct packed {
		pix_t [2:0][2:0] px;
		logic [2:0]      colp;
		logic [2:0]      rowp;
	} nbhd_t;

	// Result bookkeeping that travels alongside the lanes.
	typedef struct packed {
		logic va;
		logic vb;
		logic last_a;
	} res_flags_t;

endpackage

/* src/demg_in_if.sv */
// ----------------------------------------------------------------------------
// demg_in_if
// Column beat channel: three vertical pixels with row and edge flags.
// ----------------------------------------------------------------------------
interface demg_in_if;
	logic          valid;
	logic          ready;
	demg_pkg::pix_t pixel_above;
	demg_pkg::pix_t pixel_center;
	demg_pkg::pix_t pixel_below;
	logic          has_row_above;
	logic          has_row_below;
	logic          row_first;
	logic          row_final;

	modport source (
		output valid, pixel_above, pixel_center, pixel_below,
		output has_row_above, has_row_below, row_first, row_final,
		input  ready
	);
	modport sink (
		input  valid, pixel_above, pixel_center, pixel_below,
		input  has_row_above, has_row_below, row_first, row_final,
		output ready
	);
endinterface

/* src/demg_out_if.sv */
// ----------------------------------------------------------------------------
// demg_out_if
// Result beat channel: one edge magnitude with a last-of-item flag.
// ----------------------------------------------------------------------------
interface demg_out_if;
	logic          valid;
	logic          ready;
	demg_pkg::pix_t edge_value;
	logic          run_last;

	modport source (output valid, edge_value, run_last, input ready);
	modport sink   (input valid, edge_value, run_last, output ready);
endinterface

/* src/diagonal_edge_magnitude_3x3.sv */
// ----------------------------------------------------------------------------
// diagonal_edge_magnitude_3x3
// Diagonal Sobel edge magnitude over a streamed 3x3 window, two lanes.
// Path: neighbourhood, lane magnitude, lane quotient and output registers in turn.
// Throughput: one column per cycle unless edges stalls; a row's last column
// with a lagging pixel yields two beats through the one output register.
// Reset: asynchronous, clears the window, column count and all valid flags.
// ----------------------------------------------------------------------------
module diagonal_edge_magnitude_3x3 (
	input  logic clk,
	input  logic arst_n,
	demg_in_if.sink   columns,
	demg_out_if.source edges
);
	import demg_pkg::*;

	pix_t [5:0]  win_q;
	logic [1:0]  held_q;
	logic [1:0]  held_eff;
	logic        en, acc;
	nbhd_t       nba, nbb;
	nbhd_t       nba_s1, nbb_s1;
	res_flags_t  flags_in, flags_s1, flags_s2;
	pix_t [2:0]  cur;
	logic [2:0]  rowp;
	mag_t        qa45, qa135, qb45, qb135;

	assign columns.ready = en;
	assign acc      = columns.valid && en;
	assign held_eff = columns.row_first ? 2'd0 : held_q;
	assign cur      = {columns.pixel_below, columns.pixel_center, columns.pixel_above};
	assign rowp     = {columns.has_row_below, 1'b1, columns.has_row_above};

	always_comb begin
		nba.px   = {cur, win_q[5:3], win_q[2:0]};
		nba.colp = {1'b1, 1'b1, held_eff >= 2'd2};
		nba.rowp = rowp;
		nbb.px   = {24'd0, cur, win_q[5:3]};
		nbb.colp = {1'b0, 1'b1, held_eff >= 2'd1};
		nbb.rowp = rowp;
		flags_in.va     = acc && (held_eff >= 2'd1);
		flags_in.vb     = acc && columns.row_final;
		flags_in.last_a = !columns.row_final;
	end

	// Shift the window and count columns on each accepted beat; a row's final column clears the count instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			held_q <= 2'd0;
		end else if (acc) begin
			if (columns.row_final) begin
				held_q <= 2'd0;
			end else begin
				win_q  <= {cur, win_q[5:3]};
				held_q <= (held_eff == 2'd2) ? 2'd2 : held_eff + 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
		end else if (en) begin
			flags_s1 <= flags_in;
			flags_s2 <= flags_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nba_s1 <= nba;
			nbb_s1 <= nbb;
		end
	end

	demg_lane u_lane_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.nb_s1   (nba_s1),
		.q45_s3  (qa45),
		.q135_s3 (qa135)
	);

	demg_lane u_lane_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.nb_s1   (nbb_s1),
		.q45_s3  (qb45),
		.q135_s3 (qb135)
	);

	demg_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags_s2 (flags_s2),
		.qa45_s3  (qa45),
		.qa135_s3 (qa135),
		.qb45_s3  (qb45),
		.qb135_s3 (qb135),
		.en       (en),
		.edges    (edges)
	);

	a_held_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		held_q != 2'd3)
		else $error("column count out of range");

	a_final_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && columns.row_final) |=> (held_q == 2'd0))
		else $error("window not emptied on row end");

	a_first_no_lag: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && columns.row_first) |=> !flags_s1.va)
		else $error("lag beat raised at row start");

endmodule

/* src/demg_lane.sv */
// ----------------------------------------------------------------------------
// demg_lane
// One gradient lane: masked diagonal sums, then magnitude divided by the
// in-image weight sum when that is +/-3 or +/-4, two registered stages.
// ----------------------------------------------------------------------------
module demg_lane (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  demg_pkg::nbhd_t nb_s1,
	output demg_pkg::mag_t  q45_s3,
	output demg_pkg::mag_t  q135_s3
);
	import demg_pkg::*;

	localparam int RECIP3       = 683;
	localparam int RECIP3_SHIFT = 11;

	sum_t  s45, s135;
	wsum_t w45s, w135s;
	mag_t  m45_s2, m135_s2;
	div_t  d45_s2, d135_s2;

	function automatic div_t div_code(input wsum_t w);
		div_t d;
		d = DIV_ONE;
		if (w == 4'sd3 || w == -4'sd3)
			d = DIV_THREE;
		else if (w == 4'sd4 || w == -4'sd4)
			d = DIV_FOUR;
		return d;
	endfunction

	function automatic mag_t divide(input mag_t m, input div_t d);
		logic [19:0] prod;
		mag_t q;
		prod = 20'(m) * 20'(RECIP3);
		case (d)
			DIV_THREE: q = mag_t'(prod >> RECIP3_SHIFT);
			DIV_FOUR:  q = m >> 2;
			default:   q = m;
		endcase
		return q;
	endfunction

	always_comb begin
		s45   = '0;
		s135  = '0;
		w45s  = '0;
		w135s = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (nb_s1.colp[c] && nb_s1.rowp[r]) begin
					s45   = s45 + sum_t'({4'b0, nb_s1.px[c][r]}) * sum_t'(W45[r][c]);
					s135  = s135 + sum_t'({4'b0, nb_s1.px[c][r]}) * sum_t'(W135[r][c]);
					w45s  = w45s + wsum_t'(W45[r][c]);
					w135s = w135s + wsum_t'(W135[r][c]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m45_s2  <= '0;
			m135_s2 <= '0;
			d45_s2  <= DIV_ONE;
			d135_s2 <= DIV_ONE;
			q45_s3  <= '0;
			q135_s3 <= '0;
		end else if (en) begin
			m45_s2  <= mag_t'((s45 < 0) ? -s45 : s45);
			m135_s2 <= mag_t'((s135 < 0) ? -s135 : s135);
			d45_s2  <= div_code(w45s);
			d135_s2 <= div_code(w135s);
			q45_s3  <= divide(m45_s2, d45_s2);
			q135_s3 <= divide(m135_s2, d135_s2);
		end
	end

endmodule

/* src/demg_merge.sv */
// ----------------------------------------------------------------------------
// demg_merge
// Combine lane quotients into edge values and emit up to two beats per
// column in order through a registered output; drives the pipeline enable.
// ----------------------------------------------------------------------------
module demg_merge (
	input  logic                clk,
	input  logic                arst_n,
	input  demg_pkg::res_flags_t flags_s2,
	input  demg_pkg::mag_t       qa45_s3,
	input  demg_pkg::mag_t       qa135_s3,
	input  demg_pkg::mag_t       qb45_s3,
	input  demg_pkg::mag_t       qb135_s3,
	output logic                en,
	demg_out_if.source          edges
);
	import demg_pkg::*;

	logic pend_a_q, pend_b_q, last_a_q;
	logic out_v_q;
	logic load, sel_b;
	logic [10:0] tot;

	assign load  = (pend_a_q || pend_b_q) && (!out_v_q || edges.ready);
	assign sel_b = !pend_a_q;
	assign en    = !(pend_a_q || pend_b_q) || (load && !(pend_a_q && pend_b_q));
	assign tot   = sel_b ? (11'(qb45_s3) + 11'(qb135_s3)) : (11'(qa45_s3) + 11'(qa135_s3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
			last_a_q <= 1'b0;
		end else if (en) begin
			pend_a_q <= flags_s2.va;
			pend_b_q <= flags_s2.vb;
			last_a_q <= flags_s2.last_a;
		end else if (load) begin
			if (sel_b)
				pend_b_q <= 1'b0;
			else
				pend_a_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (edges.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			edges.edge_value <= tot[8:1];
			edges.run_last   <= sel_b ? 1'b1 : last_a_q;
		end
	end

	assign edges.valid = out_v_q;

	a_pair_drains_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_a_q && pend_b_q && load) |=> (!pend_a_q && pend_b_q))
		else $error("flush beat lost after lag beat");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(en && (pend_a_q || pend_b_q)) |-> load)
		else $error("pending beat overwritten");

	a_lag_not_last_before_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_a_q && pend_b_q) |-> !last_a_q)
		else $error("lag beat marked last ahead of flush beat");

endmodule
